>>> rtl/iss_pkg.sv
// Package for the indentation statement splitter.
// Holds the event codes, the fixed result widths and the controller/datapath structs.
// No dependencies.
package iss_pkg;

    localparam int KIND_W = 3;
    localparam int LINE_W = 21;
    localparam int LEN_W  = 21;

    localparam logic [KIND_W-1:0] KIND_TAB      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CLOSE    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_OPEN     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_STMT     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_OVERFLOW = 3'd4;
    localparam logic [KIND_W-1:0] KIND_END      = 3'd5;

    typedef struct packed {
        logic              do_step;
        logic              do_latch;
        logic              do_push;
        logic [KIND_W-1:0] push_kind;
        logic              do_pop;
        logic              do_open;
        logic              do_begin;
        logic              do_clear;
        logic              do_flush;
    } iss_cmd_t;

    typedef struct packed {
        logic in_begin;
        logic in_emits;
        logic in_last;
        logic byte_tab;
        logic pop_ok;
        logic deeper;
        logic room;
        logic in_stmt;
        logic last;
        logic pend_valid;
        logic out_free;
    } iss_status_t;

endpackage

>>> rtl/iss_ctrl.sv
// Controller state machine of the indentation statement splitter.
// Sequences each text byte through the datapath; depends on iss_pkg.
module iss_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  iss_pkg::iss_status_t status,
    output iss_pkg::iss_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_TAB   = 3'd1;
    localparam logic [2:0] ST_POP   = 3'd2;
    localparam logic [2:0] ST_EOT   = 3'd3;
    localparam logic [2:0] ST_END   = 3'd4;
    localparam logic [2:0] ST_FLUSH = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       can_push;

    assign can_push = !status.pend_valid || status.out_free;
    assign s_ready  = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.do_latch = 1'b1;
                    if (status.in_begin) begin
                        state_next = ST_TAB;
                    end else begin
                        cmd.do_step   = 1'b1;
                        cmd.do_push   = status.in_emits;
                        cmd.push_kind = iss_pkg::KIND_STMT;
                        if (status.in_last) begin
                            state_next = ST_EOT;
                        end else if (status.in_emits) begin
                            state_next = ST_FLUSH;
                        end
                    end
                end
            end
            ST_TAB: begin
                if (status.byte_tab) begin
                    cmd.do_push   = 1'b1;
                    cmd.push_kind = iss_pkg::KIND_TAB;
                end
                state_next = ST_POP;
            end
            ST_POP: begin
                if (status.pop_ok) begin
                    if (can_push) begin
                        cmd.do_push   = 1'b1;
                        cmd.push_kind = iss_pkg::KIND_CLOSE;
                        cmd.do_pop    = 1'b1;
                    end
                end else if (!status.deeper || can_push) begin
                    if (status.deeper) begin
                        cmd.do_push = 1'b1;
                        if (status.room) begin
                            cmd.push_kind = iss_pkg::KIND_OPEN;
                            cmd.do_open   = 1'b1;
                        end else begin
                            cmd.push_kind = iss_pkg::KIND_OVERFLOW;
                        end
                    end
                    cmd.do_begin = 1'b1;
                    state_next   = status.last ? ST_EOT : ST_FLUSH;
                end
            end
            ST_EOT: begin
                if (!status.in_stmt) begin
                    state_next = ST_END;
                end else if (can_push) begin
                    cmd.do_push   = 1'b1;
                    cmd.push_kind = iss_pkg::KIND_STMT;
                    state_next    = ST_END;
                end
            end
            ST_END: begin
                if (can_push) begin
                    cmd.do_push   = 1'b1;
                    cmd.push_kind = iss_pkg::KIND_END;
                    cmd.do_clear  = 1'b1;
                    state_next    = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!status.pend_valid) begin
                    state_next = ST_IDLE;
                end else if (status.out_free) begin
                    cmd.do_flush = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/iss_datapath.sv
// Datapath of the indentation statement splitter: scan state, block stack,
// pending result and output register. Depends on iss_pkg.
module iss_datapath #(
    parameter int STACK_DEPTH = 16,
    parameter int OFFSET_BITS = 20,
    parameter int INDENT_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [7:0]                   s_text_byte,
    input  logic                         s_end_of_text,
    input  logic                         m_ready,
    input  iss_pkg::iss_cmd_t            cmd,
    output iss_pkg::iss_status_t         status,
    output logic                         m_valid,
    output logic [iss_pkg::KIND_W-1:0]   m_event_kind,
    output logic [iss_pkg::LINE_W-1:0]   m_line_no,
    output logic [OFFSET_BITS-1:0]       m_start_offset,
    output logic [iss_pkg::LEN_W-1:0]    m_stmt_length,
    output logic [INDENT_BITS-1:0]       m_block_indent,
    output logic                         m_last_of_run
);

    localparam int TOP_W = $clog2(STACK_DEPTH);

    localparam logic [7:0] CH_NL  = 8'd10;
    localparam logic [7:0] CH_SP  = 8'd32;
    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_BSL = 8'd92;

    localparam logic [1:0] MODE_INDENT = 2'd0;
    localparam logic [1:0] MODE_STMT   = 2'd1;
    localparam logic [1:0] MODE_ESC    = 2'd2;

    logic [1:0]                  mode_reg, mode_next;
    logic [INDENT_BITS-1:0]      space_reg, space_next;
    logic [iss_pkg::LINE_W-1:0]  line_reg, line_next;
    logic [OFFSET_BITS-1:0]      pos_reg, pos_next;
    logic [iss_pkg::LINE_W-1:0]  sline_reg, sline_next;
    logic [OFFSET_BITS-1:0]      sstart_reg, sstart_next;
    logic [iss_pkg::LEN_W-1:0]   sbytes_reg, sbytes_next;
    logic [TOP_W-1:0]            top_reg, top_next;
    logic [INDENT_BITS-1:0]      stack_reg [STACK_DEPTH];
    logic [7:0]                  byte_reg;
    logic                        last_reg;

    logic                        pend_valid_reg;
    logic [iss_pkg::KIND_W-1:0]  pend_kind_reg;
    logic [iss_pkg::LINE_W-1:0]  pend_line_reg;
    logic [OFFSET_BITS-1:0]      pend_start_reg;
    logic [iss_pkg::LEN_W-1:0]   pend_len_reg;
    logic [INDENT_BITS-1:0]      pend_indent_reg;

    logic                        m_valid_reg;
    logic [iss_pkg::KIND_W-1:0]  out_kind_reg;
    logic [iss_pkg::LINE_W-1:0]  out_line_reg;
    logic [OFFSET_BITS-1:0]      out_start_reg;
    logic [iss_pkg::LEN_W-1:0]   out_len_reg;
    logic [INDENT_BITS-1:0]      out_indent_reg;
    logic                        out_last_reg;

    logic [iss_pkg::LINE_W-1:0]  ev_line;
    logic [OFFSET_BITS-1:0]      ev_start;
    logic [iss_pkg::LEN_W-1:0]   ev_len;
    logic [INDENT_BITS-1:0]      ev_indent;

    logic                        in_nl, in_sp, in_bsl;
    logic                        in_stmt_mode;
    logic [iss_pkg::LINE_W-1:0]  line_inc;
    logic [iss_pkg::LEN_W-1:0]   bytes_inc;
    logic [INDENT_BITS-1:0]      top_ind;
    logic [TOP_W-1:0]            top_up;
    logic                        out_free;
    logic                        out_load;

    assign in_nl        = (s_text_byte == CH_NL);
    assign in_sp        = (s_text_byte == CH_SP);
    assign in_bsl       = (s_text_byte == CH_BSL);
    assign in_stmt_mode = (mode_reg == MODE_STMT) || (mode_reg == MODE_ESC);
    assign line_inc     = (&line_reg) ? line_reg : line_reg + iss_pkg::LINE_W'(1);
    assign bytes_inc    = (&sbytes_reg) ? sbytes_reg : sbytes_reg + iss_pkg::LEN_W'(1);
    assign top_ind      = (top_reg == '0) ? '0 : stack_reg[top_reg];
    assign top_up       = top_reg + TOP_W'(1);
    assign out_free     = !m_valid_reg || m_ready;
    assign out_load     = (cmd.do_push && pend_valid_reg) || cmd.do_flush;

    assign status.in_begin   = !in_stmt_mode && !in_nl && !in_sp;
    assign status.in_emits   = (mode_reg == MODE_STMT) && in_nl;
    assign status.in_last    = s_end_of_text;
    assign status.byte_tab   = (byte_reg == CH_TAB);
    assign status.pop_ok     = (top_reg != '0) && (space_reg < top_ind);
    assign status.deeper     = (space_reg > top_ind);
    assign status.room       = (top_reg != TOP_W'(STACK_DEPTH - 1));
    assign status.in_stmt    = in_stmt_mode;
    assign status.last       = last_reg;
    assign status.pend_valid = pend_valid_reg;
    assign status.out_free   = out_free;

    always_comb begin
        mode_next   = mode_reg;
        space_next  = space_reg;
        line_next   = line_reg;
        pos_next    = pos_reg;
        sline_next  = sline_reg;
        sstart_next = sstart_reg;
        sbytes_next = sbytes_reg;
        top_next    = top_reg;
        if (cmd.do_clear) begin
            mode_next   = MODE_INDENT;
            space_next  = '0;
            line_next   = iss_pkg::LINE_W'(1);
            pos_next    = '0;
            sline_next  = iss_pkg::LINE_W'(1);
            sstart_next = '0;
            sbytes_next = '0;
            top_next    = '0;
        end else begin
            if (cmd.do_step) begin
                pos_next = pos_reg + OFFSET_BITS'(1);
                if ((mode_reg == MODE_ESC) && in_nl) begin
                    sbytes_next = bytes_inc;
                    line_next   = line_inc;
                    mode_next   = MODE_STMT;
                end else if (in_stmt_mode) begin
                    if (in_nl) begin
                        line_next  = line_inc;
                        space_next = '0;
                        mode_next  = MODE_INDENT;
                    end else if (in_bsl) begin
                        sbytes_next = bytes_inc;
                        mode_next   = MODE_ESC;
                    end else begin
                        sbytes_next = bytes_inc;
                        mode_next   = MODE_STMT;
                    end
                end else begin
                    mode_next = MODE_INDENT;
                    if (in_nl) begin
                        space_next = '0;
                        line_next  = line_inc;
                    end else if (in_sp && !(&space_reg)) begin
                        space_next = space_reg + INDENT_BITS'(1);
                    end
                end
            end
            if (cmd.do_begin) begin
                sline_next  = line_reg;
                sstart_next = pos_reg;
                sbytes_next = iss_pkg::LEN_W'(1);
                mode_next   = (byte_reg == CH_BSL) ? MODE_ESC : MODE_STMT;
                pos_next    = pos_reg + OFFSET_BITS'(1);
            end
            if (cmd.do_pop) begin
                top_next = top_reg - TOP_W'(1);
            end else if (cmd.do_open) begin
                top_next = top_up;
            end
        end
    end

    always_comb begin
        ev_line   = '0;
        ev_start  = '0;
        ev_len    = '0;
        ev_indent = '0;
        case (cmd.push_kind)
            iss_pkg::KIND_TAB: begin
                ev_line = line_reg;
            end
            iss_pkg::KIND_CLOSE: begin
                ev_indent = top_ind;
            end
            iss_pkg::KIND_OPEN: begin
                ev_indent = space_reg;
            end
            iss_pkg::KIND_OVERFLOW: begin
                ev_line   = line_reg;
                ev_indent = space_reg;
            end
            iss_pkg::KIND_STMT: begin
                ev_line  = sline_reg;
                ev_start = sstart_reg;
                ev_len   = sbytes_reg;
            end
            default: begin
                ev_line = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_INDENT;
            space_reg      <= '0;
            line_reg       <= iss_pkg::LINE_W'(1);
            pos_reg        <= '0;
            sline_reg      <= iss_pkg::LINE_W'(1);
            sstart_reg     <= '0;
            sbytes_reg     <= '0;
            top_reg        <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            mode_reg   <= mode_next;
            space_reg  <= space_next;
            line_reg   <= line_next;
            pos_reg    <= pos_next;
            sline_reg  <= sline_next;
            sstart_reg <= sstart_next;
            sbytes_reg <= sbytes_next;
            top_reg    <= top_next;
            if (cmd.do_push) begin
                pend_valid_reg <= 1'b1;
            end else if (cmd.do_flush) begin
                pend_valid_reg <= 1'b0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.do_latch) begin
            byte_reg <= s_text_byte;
            last_reg <= s_end_of_text;
        end
        if (cmd.do_open) begin
            stack_reg[top_up] <= space_reg;
        end
        if (cmd.do_push) begin
            pend_kind_reg   <= cmd.push_kind;
            pend_line_reg   <= ev_line;
            pend_start_reg  <= ev_start;
            pend_len_reg    <= ev_len;
            pend_indent_reg <= ev_indent;
        end
        if (out_load) begin
            out_kind_reg   <= pend_kind_reg;
            out_line_reg   <= pend_line_reg;
            out_start_reg  <= pend_start_reg;
            out_len_reg    <= pend_len_reg;
            out_indent_reg <= pend_indent_reg;
            out_last_reg   <= cmd.do_flush;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_event_kind   = out_kind_reg;
    assign m_line_no      = out_line_reg;
    assign m_start_offset = out_start_reg;
    assign m_stmt_length  = out_len_reg;
    assign m_block_indent = out_indent_reg;
    assign m_last_of_run  = out_last_reg;

    // A result leaves the pending stage only when the output register can take it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("output register overwritten while full");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.do_flush |-> pend_valid_reg)
        else $error("flush without a pending result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.do_pop |-> (top_reg != '0) && !cmd.do_open)
        else $error("block stack popped below the root");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.do_open |=> (top_reg == $past(top_up)) && (top_reg != '0))
        else $error("block stack push lost");

endmodule

>>> rtl/indentation_statement_splitter_unit.sv
// Top level of the indentation statement splitter.
// Joins the controller (iss_ctrl) and the datapath (iss_datapath); depends on iss_pkg.
//
//   Channel  Direction  Handshake          Payload
//   s_       in         s_valid/s_ready    text_byte, end_of_text
//   m_       out        m_valid/m_ready    event_kind, line_no, start_offset,
//                                          stmt_length, block_indent, last_of_run
//
// A byte that causes no result stays in the idle state; a newline ending a statement also
// passes flush. A byte that starts a statement passes tab, pop (again per block it closes)
// and flush; the last byte of a text adds the end-of-text and end states for the final
// statement and end results. Results pass through a pending stage and an output register;
// a stalled output holds the block only when both are full. Reset is synchronous.
module indentation_statement_splitter_unit #(
    parameter int STACK_DEPTH = 16,
    parameter int OFFSET_BITS = 20,
    parameter int INDENT_BITS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [7:0]                 s_text_byte,
    input  logic                       s_end_of_text,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [iss_pkg::KIND_W-1:0] m_event_kind,
    output logic [iss_pkg::LINE_W-1:0] m_line_no,
    output logic [OFFSET_BITS-1:0]     m_start_offset,
    output logic [iss_pkg::LEN_W-1:0]  m_stmt_length,
    output logic [INDENT_BITS-1:0]     m_block_indent,
    output logic                       m_last_of_run
);

    iss_pkg::iss_cmd_t    cmd;
    iss_pkg::iss_status_t status;

    iss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    iss_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .OFFSET_BITS (OFFSET_BITS),
        .INDENT_BITS (INDENT_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_text_byte    (s_text_byte),
        .s_end_of_text  (s_end_of_text),
        .m_ready        (m_ready),
        .cmd            (cmd),
        .status         (status),
        .m_valid        (m_valid),
        .m_event_kind   (m_event_kind),
        .m_line_no      (m_line_no),
        .m_start_offset (m_start_offset),
        .m_stmt_length  (m_stmt_length),
        .m_block_indent (m_block_indent),
        .m_last_of_run  (m_last_of_run)
    );

endmodule
